/* src/hct_pkg.sv */
// ----------------------------------------------------------------------------
// hct_pkg
// types and constants shared by the counting hash table modules
// ----------------------------------------------------------------------------
package hct_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned LenW    = 4;
  localparam int unsigned CountW  = 32;
  localparam int unsigned HomeW   = 16;
  localparam int unsigned LogW    = 4;
  localparam int unsigned SlotOutW = 10;
  localparam int unsigned UsedW   = 11;

  localparam logic [KeyW-1:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [KeyW-1:0] FnvPrimeLow = 64'h00000000000001b3;
  localparam int unsigned FnvPrimeShift = 40;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic FuncIncr  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef enum logic {
    F_IDLE,
    F_HASH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } back_state_e;

  typedef struct packed {
    logic             func;
    logic [KeyW-1:0]  key;
    logic [LenW-1:0]  len;
    logic [HomeW-1:0] hash;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic [LenW-1:0]   len;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } entry_t;

  // one fnv-1a step: multiply by 2^40 + 0x1b3 as a shift plus a narrow product
  function automatic logic [KeyW-1:0] fnv_step(input logic [KeyW-1:0] h,
                                               input logic [7:0] b);
    logic [KeyW-1:0] x;
    x = h ^ {56'd0, b};
    return (x << FnvPrimeShift) + (x * FnvPrimeLow);
  endfunction

endpackage

/* src/hct_ram.sv */
// ----------------------------------------------------------------------------
// hct_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module hct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

/* src/hct_fifo.sv */
// ----------------------------------------------------------------------------
// hct_fifo
// two-entry queue between the hashing front and the probing back
// ----------------------------------------------------------------------------
module hct_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o,
  output logic             valid_o
);

  logic [Width-1:0] buf_q [2];
  logic wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = buf_q[rp_q];

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wp_d = ~wp_q;
    end
    if (pop_i) begin
      rp_d = ~rp_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= push_data_i;
    end
  end

endmodule

/* src/hct_front.sv */
// ----------------------------------------------------------------------------
// hct_front
// accepts words, trims the key to its length and hashes one byte a cycle
// ----------------------------------------------------------------------------
module hct_front #(
  parameter int unsigned MaxKeyBytes = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enable_i,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic                 func_i,
  input  logic [63:0]          key_i,
  input  logic [3:0]           len_i,
  output logic                 push_o,
  output hct_pkg::job_t        job_o,
  input  logic                 full_i
);
  import hct_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxKeyBytes);

  front_state_e state_q, state_d;
  logic            func_q, func_d;
  logic [KeyW-1:0] key_q, key_d, h_q, h_d, key_trim;
  logic [LenW-1:0] len_q, len_d, cnt_q, cnt_d, len_sat;

  always_comb begin
    len_sat = (len_i > MaxLen) ? MaxLen : len_i;
    for (int b = 0; b < 8; b++) begin
      key_trim[8*b +: 8] = (LenW'(b) < len_sat) ? key_i[8*b +: 8] : 8'd0;
    end
  end

  assign s_ready_o = (state_q == F_IDLE) && enable_i;
  assign job_o = '{func: func_q, key: key_q, len: len_q, hash: h_q[HomeW-1:0]};

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    key_d   = key_q;
    len_d   = len_q;
    h_d     = h_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (s_valid_i && enable_i) begin
          func_d  = func_i;
          key_d   = key_trim;
          len_d   = len_sat;
          h_d     = FnvBasis;
          cnt_d   = '0;
          state_d = F_HASH;
        end
      end
      F_HASH: begin
        if (cnt_q != len_q) begin
          h_d   = fnv_step(h_q, key_q[{cnt_q[2:0], 3'b000} +: 8]);
          cnt_d = cnt_q + LenW'(1);
        end else if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    key_q  <= key_d;
    len_q  <= len_d;
    h_q    <= h_d;
    cnt_q  <= cnt_d;
  end

endmodule

/* src/hct_back.sv */
// ----------------------------------------------------------------------------
// hct_back
// clears the table after reset, probes slots and updates counts
// ----------------------------------------------------------------------------
module hct_back #(
  parameter int unsigned Slots = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [3:0]    slots_log2_i,
  output logic          ready_o,
  input  logic          q_valid_i,
  input  hct_pkg::job_t q_job_i,
  output logic          q_pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic          present_o,
  output logic [31:0]   hit_count_o,
  output logic [9:0]    slot_index_o,
  output logic [10:0]   entries_o,
  output logic          full_o
);
  import hct_pkg::*;

  localparam int unsigned SW = $clog2(Slots);
  localparam int unsigned LgMax = ((1 << SW) == Slots) ? SW : SW - 1;
  localparam logic [LogW-1:0] LgMaxV = LogW'(LgMax);

  back_state_e state_q, state_d;
  job_t        job_q, job_d;
  logic [SW-1:0] idx_q, idx_d, home_q, home_d, mask, rd_addr, wr_addr;
  logic [SW:0]   vis_q, vis_d, n_act;
  logic [LogW-1:0] lg;
  logic [UsedW-1:0] used_q, used_d;
  logic rd_en, wr_en;
  entry_t rd_ent, wr_ent;
  logic [$bits(entry_t)-1:0] rd_raw;
  logic empty, match, last, out_free;
  logic [CountW-1:0] cnt_inc;
  logic [31:0] sidx_wide;

  logic             m_valid_q, m_valid_d, pres_q, pres_d, full_q, full_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]    sidx_q, sidx_d;

  hct_ram #(.Width($bits(entry_t)), .Depth(Slots)) u_ram (
    .clk_i,
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_ent),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_raw)
  );

  assign rd_ent = entry_t'(rd_raw);
  assign lg     = (slots_log2_i > LgMaxV) ? LgMaxV : slots_log2_i;
  assign n_act  = (SW+1)'(1) << lg;
  assign mask   = SW'(n_act - (SW+1)'(1));
  assign empty  = !rd_ent.valid;
  assign match  = rd_ent.valid && (rd_ent.len == job_q.len) && (rd_ent.key == job_q.key);
  assign last   = ((vis_q + (SW+1)'(1)) == n_act);
  assign out_free = !m_valid_q || m_ready_i;
  assign cnt_inc  = (rd_ent.count == CountMax) ? CountMax : rd_ent.count + CountW'(1);
  assign ready_o  = (state_q != B_CLEAR);

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    idx_d     = idx_q;
    home_d    = home_q;
    vis_d     = vis_q;
    used_d    = used_q;
    m_valid_d = m_valid_q && !m_ready_i;
    pres_d    = pres_q;
    cnt_d     = cnt_q;
    sidx_d    = sidx_q;
    full_d    = full_q;
    q_pop_o   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    wr_en     = 1'b0;
    wr_addr   = idx_q;
    wr_ent    = '0;
    unique case (state_q)
      B_CLEAR: begin
        wr_en = 1'b1;
        idx_d = idx_q + SW'(1);
        if (idx_q == SW'(Slots - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          job_d   = q_job_i;
          home_d  = q_job_i.hash[SW-1:0] & mask;
          idx_d   = home_d;
          vis_d   = '0;
          rd_en   = 1'b1;
          rd_addr = home_d;
          state_d = B_PROBE;
        end
      end
      B_PROBE: begin
        if (!empty && !match && !last) begin
          idx_d   = (idx_q + SW'(1)) & mask;
          vis_d   = vis_q + (SW+1)'(1);
          rd_en   = 1'b1;
          rd_addr = idx_d;
        end else if (out_free) begin
          m_valid_d = 1'b1;
          state_d   = B_IDLE;
          full_d    = 1'b0;
          sidx_d    = idx_q;
          pres_d    = 1'b0;
          cnt_d     = '0;
          if (!empty && !match) begin
            full_d = 1'b1;
            sidx_d = home_q;
          end else if (job_q.func == FuncIncr) begin
            wr_en  = 1'b1;
            wr_ent = '{valid: 1'b1, len: job_q.len, key: job_q.key,
                       count: empty ? CountW'(1) : cnt_inc};
            pres_d = 1'b1;
            cnt_d  = wr_ent.count;
            if (empty) begin
              used_d = used_q + UsedW'(1);
            end
          end else if (match) begin
            pres_d = 1'b1;
            cnt_d  = rd_ent.count;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_CLEAR;
      idx_q     <= '0;
      used_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      used_q    <= used_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    home_q <= home_d;
    vis_q  <= vis_d;
    pres_q <= pres_d;
    cnt_q  <= cnt_d;
    sidx_q <= sidx_d;
    full_q <= full_d;
  end

  assign sidx_wide    = 32'(sidx_q);
  assign m_valid_o    = m_valid_q;
  assign present_o    = pres_q;
  assign hit_count_o  = cnt_q;
  assign slot_index_o = sidx_wide[SlotOutW-1:0];
  assign entries_o    = used_q;
  assign full_o       = full_q;

endmodule

/* src/hash_count_table.sv */
// ----------------------------------------------------------------------------
// hash_count_table
// counting hash table with fnv-1a hashing and linear probing
// ----------------------------------------------------------------------------
// input words carry a key (up to eight bytes, byte 0 lowest), its length and
// an operation in tuser: 0 counts the key, 1 only looks it up. each word gives
// one output word with presence, count, slot, occupancy and a full flag.
// the front hashes one byte a cycle, then the
// back reads one slot a cycle through the table ram's single read port
// and registers the result. front and back overlap through a two-entry
// queue, so the sustained rate is set by the slower of the two. after
// reset the back writes every slot empty, and tready stays low until that
// pass is done. a stalled output holds its word; the front keeps accepting
// until the queue fills. active_slots_log2 reads back at byte address 0 of
// the register port, and writes to it do not decode paddr;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module hash_count_table #(
  parameter int unsigned Slots       = 1024,
  parameter int unsigned MaxKeyBytes = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // key_bytes[63:0], key_length[67:64], zero
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // present[0], hit_count[32:1], slot_index[42:33], entries_in_use[53:43],
  // table_full[54], zero
  output logic [55:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hct_pkg::*;

  logic [LogW-1:0] lg_q;
  logic  ready, push, full, qv, pop;
  job_t  job_in, job_out;
  logic  pres, tfull;
  logic [CountW-1:0] cnt;
  logic [SlotOutW-1:0] sidx;
  logic [UsedW-1:0] used;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, lg_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= LogW'(10);
    end else if (psel && penable && pwrite) begin
      lg_q <= pwdata[LogW-1:0];
    end
  end

  hct_front #(.MaxKeyBytes(MaxKeyBytes)) u_front (
    .clk_i,
    .rst_ni,
    .enable_i (ready),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .func_i   (s_axis_tuser),
    .key_i    (s_axis_tdata[63:0]),
    .len_i    (s_axis_tdata[67:64]),
    .push_o   (push),
    .job_o    (job_in),
    .full_i   (full)
  );

  hct_fifo #(.Width($bits(job_t))) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_data_i(job_in),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (job_out),
    .valid_o    (qv)
  );

  hct_back #(.Slots(Slots)) u_back (
    .clk_i,
    .rst_ni,
    .slots_log2_i(lg_q),
    .ready_o     (ready),
    .q_valid_i   (qv),
    .q_job_i     (job_out),
    .q_pop_o     (pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .present_o   (pres),
    .hit_count_o (cnt),
    .slot_index_o(sidx),
    .entries_o   (used),
    .full_o      (tfull)
  );

  assign m_axis_tdata = {1'b0, tfull, used, sidx, cnt, pres};

endmodule

/* tb/sv/hash_count_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_count_table_tb
// self-checking bench for the counting hash table
// ----------------------------------------------------------------------------
// keys go in on the input stream; a shadow table with its own fnv-1a hash and
// linear probe works out each output word, which is checked field by field
// in arrival order. directed words cover the corner cases, then random words
// mostly from a small reused key pool run over several table sizes and idle mixes.
// ----------------------------------------------------------------------------
module hash_count_table_tb;
  import hct_pkg::*;

  localparam int unsigned NumSlots = 1024;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic        present;
    logic [31:0] hit_count;
    logic [9:0]  slot_index;
    logic [10:0] entries_in_use;
    logic        table_full;
  } lookup_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // key_bytes[63:0], key_length[67:64], zero
  logic        s_axis_tuser = 1'b0;  // func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // present[0], hit_count[32:1], slot_index[42:33], entries_in_use[53:43],
  // table_full[54], zero
  logic [55:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow table
  logic        shadow_valid [NumSlots];
  logic [63:0] shadow_key   [NumSlots];
  logic [3:0]  shadow_len   [NumSlots];
  logic [31:0] shadow_count [NumSlots];
  int unsigned shadow_used;
  logic [3:0]  shadow_log2;

  lookup_t     pending_lookups [$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic [63:0] key_pool [48];
  logic [3:0]  len_pool [48];

  hash_count_table dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic lookup_t count_key(logic func, logic [63:0] key_in,
                                        logic [3:0] len_in);
    lookup_t r;
    logic [63:0] key;
    logic [63:0] h;
    int unsigned len, n, mask, home, i, visited;
    bit found, empty;
    r = '0;
    found = 0;
    empty = 0;
    len = (len_in > 8) ? 8 : len_in;
    key = (len < 8) ? (key_in & ((64'd1 << (8 * len)) - 1)) : key_in;
    h = 64'hcbf29ce484222325;
    for (int b = 0; b < len; b++) h = (h ^ ((key >> (8 * b)) & 64'hff)) * 64'h100000001b3;
    n = 1 << shadow_log2;
    if (n > NumSlots) n = NumSlots;
    mask = n - 1;
    home = h[31:0] & mask;
    i = home;
    for (visited = 0; visited < n; visited++) begin
      if (!shadow_valid[i]) begin
        empty = 1;
        break;
      end
      if (shadow_len[i] == len && shadow_key[i] == key) begin
        found = 1;
        break;
      end
      i = (i + 1) & mask;
    end
    if (!found && !empty) begin
      r.table_full = 1'b1;
      i = home;
    end else if (func == FuncIncr) begin
      if (empty) begin
        shadow_valid[i] = 1'b1;
        shadow_key[i] = key;
        shadow_len[i] = 4'(len);
        shadow_count[i] = '0;
        shadow_used++;
      end
      if (shadow_count[i] != CountMax) shadow_count[i]++;
      r.present = 1'b1;
      r.hit_count = shadow_count[i];
    end else if (found) begin
      r.present = 1'b1;
      r.hit_count = shadow_count[i];
    end
    r.slot_index = i[9:0];
    r.entries_in_use = shadow_used[10:0];
    return r;
  endfunction

  // result checker and output backpressure
  always @(posedge clk_i) begin
    lookup_t want, got;
    if (m_axis_tvalid && m_axis_tready) begin
      got.present = m_axis_tdata[0];
      got.hit_count = m_axis_tdata[32:1];
      got.slot_index = m_axis_tdata[42:33];
      got.entries_in_use = m_axis_tdata[53:43];
      got.table_full = m_axis_tdata[54];
      if (pending_lookups.size() == 0) begin
        $error("unexpected word %h", m_axis_tdata);
        failures++;
      end else begin
        want = pending_lookups.pop_front();
        if (got.present !== want.present) begin
          $error("present: expected %0d, actual %0d", want.present, got.present);
          failures++;
        end
        if (got.hit_count !== want.hit_count) begin
          $error("hit_count: expected %0d, actual %0d", want.hit_count, got.hit_count);
          failures++;
        end
        if (got.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
          failures++;
        end
        if (got.entries_in_use !== want.entries_in_use) begin
          $error("entries_in_use: expected %0d, actual %0d", want.entries_in_use,
                 got.entries_in_use);
          failures++;
        end
        if (got.table_full !== want.table_full) begin
          $error("table_full: expected %0d, actual %0d", want.table_full, got.table_full);
          failures++;
        end
      end
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_key(logic func, logic [63:0] key, logic [3:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'd0, len, key};
    s_axis_tuser <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_lookups.push_back(count_key(func, key, len));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_slots_log2(logic [3:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= {$urandom_range(0, 1) ? 28'hfffffff : 28'h0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_log2 = value;
  endtask

  task automatic test_directed();
    send_key(FuncIncr, 64'h0, 4'd0);
    send_key(FuncQuery, 64'hffff_ffff_ffff_ffff, 4'd0);
    send_key(FuncIncr, 64'hffff_ffff_ffff_ffff, 4'd8);
    send_key(FuncIncr, 64'hffff_ffff_ffff_ffff, 4'd15);
    send_key(FuncQuery, 64'hffff_ffff_ffff_ffff, 4'd12);
    send_key(FuncIncr, 64'haaaa_aaaa_aaaa_aaaa, 4'd8);
    send_key(FuncIncr, 64'h5555_5555_5555_5555, 4'd8);
    // bytes past the length are ignored
    send_key(FuncIncr, 64'hdead_beef_0012_3456, 4'd3);
    send_key(FuncQuery, 64'h0000_0000_0012_3456, 4'd3);
    send_key(FuncIncr, 64'h5555_5555_5512_3456, 4'd3);
    send_key(FuncQuery, 64'h0123_4567_89ab_cdef, 4'd7);
    send_key(FuncQuery, 64'h0, 4'd8);
    send_key(FuncIncr, 64'h0, 4'd8);
    send_key(FuncQuery, 64'h0, 4'd8);
    send_key(FuncQuery, 64'h0, 4'd4);
    wait_drained();
  endtask

  task automatic test_small_tables();
    // single slot: fills at once, then reports full
    write_slots_log2(4'd0);
    send_key(FuncIncr, 64'h11, 4'd1);
    send_key(FuncIncr, 64'h22, 4'd1);
    send_key(FuncQuery, 64'h22, 4'd1);
    send_key(FuncQuery, 64'hffff_ffff_ffff_ffff, 4'd8);
    wait_drained();
    write_slots_log2(4'd2);
    for (int k = 0; k < 6; k++) send_key(FuncIncr, 64'h7700 + k, 4'd2);
    send_key(FuncQuery, 64'h7703, 4'd2);
    wait_drained();
    // above the slot count: saturates to the full table
    write_slots_log2(4'd15);
    send_key(FuncQuery, 64'h7701, 4'd2);
    send_key(FuncIncr, 64'h7705, 4'd2);
    wait_drained();
  endtask

  task automatic test_random(int unsigned words, logic [3:0] log2, int unsigned s_idle,
                             int unsigned r_idle);
    int unsigned p;
    logic [63:0] key;
    logic [3:0] len;
    write_slots_log2(log2);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int k = 0; k < 48; k++) begin
      key_pool[k] = {$urandom, $urandom};
      len_pool[k] = 4'($urandom_range(0, 15));
    end
    for (int unsigned w = 0; w < words; w++) begin
      if ($urandom_range(99) < 85) begin
        p = $urandom_range(0, 47);
        len = len_pool[p];
        key = key_pool[p];
        if (len < 8) key = key | ({$urandom, $urandom} << (8 * len));
      end else begin
        key = {$urandom, $urandom};
        len = 4'($urandom_range(0, 15));
      end
      send_key(($urandom_range(99) < 30) ? FuncQuery : FuncIncr, key, len);
      // no-gap stretches
      if ($urandom_range(99) < 2) begin
        send_idle_pct = 0;
      end else if ($urandom_range(99) < 2) begin
        send_idle_pct = s_idle;
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int k = 0; k < NumSlots; k++) begin
      shadow_valid[k] = 1'b0;
      shadow_key[k] = '0;
      shadow_len[k] = '0;
      shadow_count[k] = '0;
    end
    shadow_used = 0;
    shadow_log2 = 4'd10;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_small_tables();
    test_random(380, 4'd10, 34, 72);
    test_random(330, 4'd3, 72, 34);
    test_random(380, 4'd6, 0, 0);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
